// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the options parser RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DOPT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define DOPT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== src/dopt_pkg.sv =====
// ---------------------------------------------------------------------------
// dopt_pkg
// Types and option codes shared by the DHCP options parser modules.
// ---------------------------------------------------------------------------
package dopt_pkg;

   localparam logic [7:0] OPT_PAD        = 8'd0;
   localparam logic [7:0] OPT_END        = 8'd255;
   localparam logic [7:0] OPT_MSG_TYPE   = 8'd53;
   localparam logic [7:0] OPT_SERVER_ID  = 8'd54;
   localparam logic [7:0] OPT_ROUTER     = 8'd3;
   localparam logic [7:0] OPT_BCAST      = 8'd28;
   localparam logic [7:0] OPT_MASK       = 8'd1;
   localparam logic [7:0] OPT_DNS        = 8'd6;

   localparam int NUM_ADDRS = 5;

   typedef enum logic [1:0] {
      PH_CODE  = 2'd0,
      PH_LEN   = 2'd1,
      PH_VALUE = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] opt_byte;
      logic       first;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0]  msg_type;
      logic [31:0] server_id;
      logic [31:0] router_addr;
      logic [31:0] bcast_addr;
      logic [31:0] subnet_mask;
      logic [31:0] dns_addr;
      logic [5:0]  seen_mask;
      logic        status;
   } rsp_type;

   // Result event raised by the parser for one byte.
   typedef struct packed {
      logic emit;
      logic status;
   } event_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] idx;
   } slot_type;

   // Map an address option code onto its capture slot.
   function automatic slot_type addr_slot(input logic [7:0] code);
      slot_type s;
      s.hit = 1'b1;
      s.idx = 3'd0;
      unique case (code)
         OPT_SERVER_ID: s.idx = 3'd0;
         OPT_ROUTER:    s.idx = 3'd1;
         OPT_BCAST:     s.idx = 3'd2;
         OPT_MASK:      s.idx = 3'd3;
         OPT_DNS:       s.idx = 3'd4;
         default:       s.hit = 1'b0;
      endcase
      return s;
   endfunction

endpackage

// ===== src/dopt_parser.sv =====
// ---------------------------------------------------------------------------
// dopt_parser
// Option record walker and capture registers; one byte per step.
// ---------------------------------------------------------------------------
module dopt_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  dopt_pkg::req_type item,
   output dopt_pkg::event_type ev,
   output dopt_pkg::rsp_type result
);

   dopt_pkg::phase_type phase_ff, phase_in, ph;
   logic [7:0]  cur_code_ff, cur_code_in, code;
   logic [7:0]  remaining_ff, remaining_in, rem;
   logic [2:0]  value_index_ff, value_index_in, idx;   // saturates at 4
   logic        done_ff, done_in, dn;
   logic [7:0]  type_ff, type_in, typ;
   logic [dopt_pkg::NUM_ADDRS-1:0][31:0] addrs_ff, addrs_in, addrs;
   logic [5:0]  seen_ff, seen_in, seen;
   dopt_pkg::slot_type slot;
   logic [1:0]  lane;

   always_comb begin
      // Start from the cleared state on the first byte.
      ph    = item.first ? dopt_pkg::PH_CODE : phase_ff;
      code  = item.first ? 8'd0 : cur_code_ff;
      rem   = item.first ? 8'd0 : remaining_ff;
      idx   = item.first ? 3'd0 : value_index_ff;
      dn    = item.first ? 1'b0 : done_ff;
      typ   = item.first ? 8'd0 : type_ff;
      addrs = item.first ? '0 : addrs_ff;
      seen  = item.first ? 6'd0 : seen_ff;

      phase_in       = ph;
      cur_code_in    = code;
      remaining_in   = rem;
      value_index_in = idx;
      done_in        = dn;
      type_in        = typ;
      addrs_in       = addrs;
      seen_in        = seen;
      ev             = '0;
      slot           = dopt_pkg::addr_slot(code);
      lane           = 2'd3 - idx[1:0];

      if (!dn) begin
         unique case (ph)
            dopt_pkg::PH_LEN: begin
               remaining_in   = item.opt_byte;
               value_index_in = 3'd0;
               phase_in       = (item.opt_byte == 8'd0) ? dopt_pkg::PH_CODE
                                                         : dopt_pkg::PH_VALUE;
            end
            dopt_pkg::PH_VALUE: begin
               if (code == dopt_pkg::OPT_MSG_TYPE) begin
                  if (idx == 3'd0) begin
                     type_in    = item.opt_byte;
                     seen_in[0] = 1'b1;
                  end
               end else if (slot.hit) begin
                  for (int i = 0; i < dopt_pkg::NUM_ADDRS; i++) begin
                     if (slot.idx == 3'(i)) begin
                        if (idx == 3'd0) begin
                           seen_in[i+1] = 1'b0;
                           addrs_in[i]  = {item.opt_byte, 24'd0};
                        end else if (idx < 3'd4) begin
                           addrs_in[i][8*lane +: 8] = item.opt_byte;
                           if (idx == 3'd3) begin
                              seen_in[i+1] = 1'b1;
                           end
                        end
                     end
                  end
               end
               if (idx < 3'd4) begin
                  value_index_in = idx + 3'd1;
               end
               remaining_in = rem - 8'd1;
               if (remaining_in == 8'd0) begin
                  phase_in = dopt_pkg::PH_CODE;
               end
            end
            default: begin
               phase_in = dopt_pkg::PH_CODE;
               if (item.opt_byte == dopt_pkg::OPT_END) begin
                  done_in   = 1'b1;
                  ev.emit   = 1'b1;
                  ev.status = 1'b0;
               end else if (item.opt_byte != dopt_pkg::OPT_PAD) begin
                  cur_code_in = item.opt_byte;
                  phase_in    = dopt_pkg::PH_LEN;
               end
            end
         endcase
         // Truncation: last byte parsed without an end option.
         if (item.last && !ev.emit) begin
            done_in   = 1'b1;
            ev.emit   = 1'b1;
            ev.status = 1'b1;
         end
      end

      result.msg_type    = type_in;
      result.server_id   = addrs_in[0];
      result.router_addr = addrs_in[1];
      result.bcast_addr  = addrs_in[2];
      result.subnet_mask = addrs_in[3];
      result.dns_addr    = addrs_in[4];
      result.seen_mask   = seen_in;
      result.status      = ev.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= dopt_pkg::PH_CODE;
         cur_code_ff    <= 8'd0;
         remaining_ff   <= 8'd0;
         value_index_ff <= 3'd0;
         done_ff        <= 1'b0;
         type_ff        <= 8'd0;
         addrs_ff       <= '0;
         seen_ff        <= 6'd0;
      end else if (step) begin
         phase_ff       <= phase_in;
         cur_code_ff    <= cur_code_in;
         remaining_ff   <= remaining_in;
         value_index_ff <= value_index_in;
         done_ff        <= done_in;
         type_ff        <= type_in;
         addrs_ff       <= addrs_in;
         seen_ff        <= seen_in;
      end
   end

`include "assert_macros.svh"

   `DOPT_ASSERT_IMP(a_done_silent, clock, reset,
      step && done_ff && !item.first, !ev.emit)
   `DOPT_ASSERT_NEXT(a_value_closes, clock, reset,
      step && !item.first && !done_ff && phase_ff == dopt_pkg::PH_VALUE &&
      remaining_ff == 8'd1, phase_ff == dopt_pkg::PH_CODE || done_ff)
   `DOPT_ASSERT_NEXT(a_emit_sets_done, clock, reset, step && ev.emit, done_ff)

endmodule

// ===== src/dhcp_option_tlv_parser_unit.sv =====
// ---------------------------------------------------------------------------
// dhcp_option_tlv_parser_unit
// DHCP options area parser: walks code/length/value records byte by byte and
// reports message type and address options at end option or truncation.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   req_    | in        | req_valid/req_ready  | req_data (opt_byte,first,last)
//   rsp_    | out       | rsp_valid/rsp_ready  | rsp_data (captures, status)
//
// One byte per cycle is accepted in steady state. A byte is held in the input
// register until it is parsed there; a result it causes is loaded into the
// result register at the edge that ends that parsing step, which raises
// rsp_valid. A result still waiting on rsp_ready stalls the input stage and
// the parser: no byte is parsed, whether or not it would cause a result,
// until the result register is free or draining. Reset clears the parser
// state and all captures.
//
module dhcp_option_tlv_parser_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dopt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dopt_pkg::rsp_type rsp_data
);

   logic                in_valid_ff, in_valid_in;
   dopt_pkg::req_type   in_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   dopt_pkg::rsp_type   rsp_data_ff;
   logic                advance;
   logic                step;
   logic                req_accept;
   dopt_pkg::event_type ev;
   dopt_pkg::rsp_type   result;

   // Advance the input stage whenever the result register is free or draining.
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign step       = in_valid_ff && advance;
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (step && ev.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on transaction, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (step && ev.emit) begin
         rsp_data_ff <= result;
      end
   end

   dopt_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_data_ff),
      .ev     (ev),
      .result (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "assert_macros.svh"

   `DOPT_ASSERT_NEXT(a_accept_loads, clock, reset, req_accept, in_valid_ff)
   `DOPT_ASSERT_NEXT(a_rsp_drains, clock, reset,
      rsp_valid_ff && rsp_ready && !(step && ev.emit), !rsp_valid_ff)
   `DOPT_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid_ff && !rsp_ready,
      rsp_valid_ff && $stable(rsp_data_ff))

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// DHCP options parser testbench
// Feeds option bytes through the request channel, predicts each report from
// a behavioral parser kept in step with accepted bytes, and checks every
// report field by field under several flow-control mixes.
// ---------------------------------------------------------------------------
module testbench;

   localparam int CLOCK_HALF      = 1;
   localparam int RESET_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int PHASE_ITEMS     = 175;
   localparam int PHASE_REPORTS   = 12;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES    = 8;

   localparam logic [7:0] CAPTURED_CODES [6] = '{
      dopt_pkg::OPT_MSG_TYPE, dopt_pkg::OPT_SERVER_ID, dopt_pkg::OPT_ROUTER,
      dopt_pkg::OPT_BCAST, dopt_pkg::OPT_MASK, dopt_pkg::OPT_DNS
   };

   // One row of the directed table: the byte, and a report typed in by hand
   // where it is plain to see; other rows lean on the behavioral parser.
   typedef struct packed {
      dopt_pkg::req_type req;
      logic              typed;
      dopt_pkg::rsp_type want;
   } plan_row_type;

   localparam dopt_pkg::rsp_type EMPTY_ENDED     = '{8'h00, 32'h0, 32'h0, 32'h0,
                                                     32'h0, 32'h0, 6'b000000, 1'b0};
   localparam dopt_pkg::rsp_type EMPTY_TRUNCATED = '{8'h00, 32'h0, 32'h0, 32'h0,
                                                     32'h0, 32'h0, 6'b000000, 1'b1};
   localparam dopt_pkg::rsp_type ALL_ONES_ENDED  = '{8'hFF, 32'hFFFF_FFFF, 32'h0,
                                                     32'h0, 32'h0, 32'h0, 6'b000011,
                                                     1'b0};

   localparam plan_row_type DIRECTED_PLAN [24] = '{
      // end option straight out of reset, no first byte seen yet
      '{'{dopt_pkg::OPT_END, 1'b0, 1'b0}, 1'b1, EMPTY_ENDED},
      // message type with a spare value byte that must be skipped
      '{'{dopt_pkg::OPT_MSG_TYPE, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'd2, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
      // full server identifier at the top of the byte range
      '{'{dopt_pkg::OPT_SERVER_ID, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'd4, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{dopt_pkg::OPT_PAD, 1'b0, 1'b0}, 1'b0, '0},
      // end option carrying the last mark
      '{'{dopt_pkg::OPT_END, 1'b0, 1'b1}, 1'b1, ALL_ONES_ENDED},
      // trailing byte after end with a last mark: no report
      '{'{8'd7, 1'b0, 1'b1}, 1'b0, '0},
      // zero-length router, then a short router, then a repeat cut short
      '{'{dopt_pkg::OPT_ROUTER, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'd0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{dopt_pkg::OPT_ROUTER, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'd2, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hAA, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hBB, 1'b0, 1'b0}, 1'b0, '0},
      '{'{dopt_pkg::OPT_ROUTER, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'd1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hCC, 1'b0, 1'b1}, 1'b0, '0},
      // a one-byte area: pad marked both first and last
      '{'{dopt_pkg::OPT_PAD, 1'b1, 1'b1}, 1'b1, EMPTY_TRUNCATED}
   };

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   dopt_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   dopt_pkg::rsp_type rsp_data;

   // Flow-control knobs: idle and stall chances in percent of cycles, and a receiver hold-off.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int rsp_hold_left  = 0;

   int items_sent       = 0;
   int frames_sent      = 0;
   int reports_expected = 0;
   int reports_checked  = 0;
   int error_count      = 0;
   int quiet_cycles     = 0;

   dopt_pkg::rsp_type pending_reports [$];

   // Behavioral parser state.
   dopt_pkg::phase_type parse_phase;
   logic [7:0]          parse_code;
   logic [7:0]          bytes_left;
   logic [7:0]          value_pos;
   logic                frame_done;
   logic [7:0]          cap_type;
   logic [31:0]         cap_addr [dopt_pkg::NUM_ADDRS];
   logic [5:0]          cap_seen;

   dhcp_option_tlv_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic void clear_parser();
      parse_phase = dopt_pkg::PH_CODE;
      parse_code  = '0;
      bytes_left  = '0;
      value_pos   = '0;
      frame_done  = 1'b0;
      cap_type    = '0;
      foreach (cap_addr[i]) cap_addr[i] = '0;
      cap_seen    = '0;
   endfunction

   function automatic dopt_pkg::rsp_type capture_report(input logic status);
      dopt_pkg::rsp_type r;
      r.msg_type    = cap_type;
      r.server_id   = cap_addr[0];
      r.router_addr = cap_addr[1];
      r.bcast_addr  = cap_addr[2];
      r.subnet_mask = cap_addr[3];
      r.dns_addr    = cap_addr[4];
      r.seen_mask   = cap_seen;
      r.status      = status;
      return r;
   endfunction

   // Advance the parser by one accepted byte; return 1 when a report is due.
   function automatic logic parse_option_byte(input dopt_pkg::req_type b,
                                              output dopt_pkg::rsp_type report);
      int slot;
      report = '0;
      if (b.first) clear_parser();
      if (frame_done) return 1'b0;

      case (parse_phase)
         dopt_pkg::PH_LEN: begin
            bytes_left  = b.opt_byte;
            value_pos   = '0;
            parse_phase = (b.opt_byte == 8'd0) ? dopt_pkg::PH_CODE : dopt_pkg::PH_VALUE;
         end
         dopt_pkg::PH_VALUE: begin
            case (parse_code)
               dopt_pkg::OPT_SERVER_ID: slot = 0;
               dopt_pkg::OPT_ROUTER:    slot = 1;
               dopt_pkg::OPT_BCAST:     slot = 2;
               dopt_pkg::OPT_MASK:      slot = 3;
               dopt_pkg::OPT_DNS:       slot = 4;
               default:                 slot = -1;
            endcase
            if (parse_code == dopt_pkg::OPT_MSG_TYPE) begin
               if (value_pos == 8'd0) begin
                  cap_type    = b.opt_byte;
                  cap_seen[0] = 1'b1;
               end
            end else if (slot >= 0) begin
               // first value byte restarts the capture and drops the seen bit
               if (value_pos == 8'd0) begin
                  cap_seen[slot + 1] = 1'b0;
                  cap_addr[slot]     = {b.opt_byte, 24'h0};
               end else if (value_pos < 8'd4) begin
                  cap_addr[slot][31 - 8 * int'(value_pos) -: 8] = b.opt_byte;
                  if (value_pos == 8'd3) cap_seen[slot + 1] = 1'b1;
               end
            end
            if (value_pos != 8'hFF) value_pos++;
            bytes_left--;
            if (bytes_left == 8'd0) parse_phase = dopt_pkg::PH_CODE;
         end
         default: begin
            // unused phase encodings fall in here as expect-code
            parse_phase = dopt_pkg::PH_CODE;
            if (b.opt_byte == dopt_pkg::OPT_END) begin
               frame_done = 1'b1;
               report     = capture_report(1'b0);
               return 1'b1;
            end
            if (b.opt_byte != dopt_pkg::OPT_PAD) begin
               parse_code  = b.opt_byte;
               parse_phase = dopt_pkg::PH_LEN;
            end
         end
      endcase

      if (b.last) begin
         frame_done = 1'b1;
         report     = capture_report(1'b1);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Offer one byte, hold it until accepted, then queue the report it causes.
   task automatic offer_byte(input dopt_pkg::req_type b, input logic typed,
                             input dopt_pkg::rsp_type typed_report);
      dopt_pkg::rsp_type predicted;
      logic              has_report;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      has_report = parse_option_byte(b, predicted);
      if (typed) begin
         has_report = 1'b1;
         predicted  = typed_report;
      end
      if (has_report) begin
         pending_reports.push_back(predicted);
         reports_expected++;
      end
   endtask

   // Build one options area: mostly well-formed records with random content,
   // some cut short, some with junk trailing the end option.
   task automatic offer_random_frame();
      dopt_pkg::req_type frame [$];
      dopt_pkg::req_type b;
      logic [7:0]        code;
      int                option_count;
      int                len;
      int                pick;
      int                cut;
      b            = '0;
      option_count = $urandom_range(0, 6);
      for (int i = 0; i < option_count; i++) begin
         pick = $urandom_range(99);
         if (pick < 65) code = CAPTURED_CODES[$urandom_range(5)];
         else if (pick < 75) code = dopt_pkg::OPT_PAD;
         else code = 8'($urandom_range(1, 254));
         b.opt_byte = code;
         frame.push_back(b);
         if (code == dopt_pkg::OPT_PAD) continue;
         if ($urandom_range(49) == 0) len = $urandom_range(255);
         else if (code inside {CAPTURED_CODES} && $urandom_range(99) < 70)
            len = (code == dopt_pkg::OPT_MSG_TYPE) ? 1 : 4;
         else len = $urandom_range(8);
         b.opt_byte = 8'(len);
         frame.push_back(b);
         repeat (len) begin
            b.opt_byte = 8'($urandom);
            frame.push_back(b);
         end
      end
      b.opt_byte = dopt_pkg::OPT_END;
      frame.push_back(b);

      pick = $urandom_range(99);
      if (pick < 15) begin
         repeat ($urandom_range(1, 3)) begin
            b.opt_byte = 8'($urandom);
            frame.push_back(b);
         end
      end else if (pick < 35) begin
         // truncate: the last mark lands on any byte, and whatever follows it is dropped
         cut   = $urandom_range(frame.size() - 1);
         frame = frame[0:cut];
      end
      frame[0].first           = 1'b1;
      frame[frame.size()-1].last = 1'b1;
      frames_sent++;
      foreach (frame[i]) offer_byte(frame[i], 1'b0, '0);
   endtask

   // Loose bytes with random marks, to break up the frame structure.
   task automatic offer_noise();
      dopt_pkg::req_type b;
      repeat ($urandom_range(1, 4)) begin
         b.opt_byte = 8'($urandom);
         b.first    = ($urandom_range(9) == 0);
         b.last     = ($urandom_range(3) == 0);
         offer_byte(b, 1'b0, '0);
      end
   endtask

   function automatic void check_report(input dopt_pkg::rsp_type want,
                                        input dopt_pkg::rsp_type got);
      if (got.msg_type !== want.msg_type) begin
         $error("msg_type: expected %0h, got %0h", want.msg_type, got.msg_type);
         error_count++;
      end
      if (got.server_id !== want.server_id) begin
         $error("server_id: expected %0h, got %0h", want.server_id, got.server_id);
         error_count++;
      end
      if (got.router_addr !== want.router_addr) begin
         $error("router_addr: expected %0h, got %0h", want.router_addr, got.router_addr);
         error_count++;
      end
      if (got.bcast_addr !== want.bcast_addr) begin
         $error("bcast_addr: expected %0h, got %0h", want.bcast_addr, got.bcast_addr);
         error_count++;
      end
      if (got.subnet_mask !== want.subnet_mask) begin
         $error("subnet_mask: expected %0h, got %0h", want.subnet_mask, got.subnet_mask);
         error_count++;
      end
      if (got.dns_addr !== want.dns_addr) begin
         $error("dns_addr: expected %0h, got %0h", want.dns_addr, got.dns_addr);
         error_count++;
      end
      if (got.seen_mask !== want.seen_mask) begin
         $error("seen_mask: expected %0b, got %0b", want.seen_mask, got.seen_mask);
         error_count++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0b, got %0b", want.status, got.status);
         error_count++;
      end
   endfunction

   // Receiver: a requested hold-off wins, else stall at the current rate.
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each report transaction with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("report arrived with nothing expected: %p", rsp_data);
            error_count++;
         end else begin
            check_report(pending_reports.pop_front(), rsp_data);
            reports_checked++;
         end
      end
   end

   // Watchdog: end the run if neither channel moves a transaction for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int send_mix [4];
      int recv_mix [4];
      int phase_items;
      int phase_reports;
      send_mix = '{0, 69, 0, 31};
      recv_mix = '{0, 0, 69, 31};
      clear_parser();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table with no idling on either side.
      foreach (DIRECTED_PLAN[i])
         offer_byte(DIRECTED_PLAN[i].req, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);

      // Hold the receiver off while one-byte areas keep coming, so the result
      // register fills and the input side has to stall.
      rsp_hold_left = HOLD_OFF_CYCLES;
      repeat (16) offer_byte('{dopt_pkg::OPT_END, 1'b1, 1'b1}, 1'b0, '0);

      // Random frames and loose noise bytes across the four flow-control mixes.
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_mix[p];
         recv_stall_pct = recv_mix[p];
         phase_items    = items_sent;
         phase_reports  = reports_expected;
         while (items_sent - phase_items < PHASE_ITEMS ||
                reports_expected - phase_reports < PHASE_REPORTS) begin
            if ($urandom_range(9) == 0) offer_noise();
            else offer_random_frame();
         end
      end

      // Drop valid, drain the outstanding reports, then watch for strays.
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d option bytes in %0d random frames plus directed cases;",
               items_sent, frames_sent);
      $display("checked %0d reports under four idle/stall mixes and one long hold-off.",
               reports_checked);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
